>>> rtl/srsp_pkg.sv
// Shared types and constants of the store record stream parser.
package srsp_pkg;

  // Header checks.
  localparam int unsigned MIN_PACKET_BYTES = 16;
  localparam int unsigned MAX_RECORDS      = 65535;

  // Result queue depth; it must be a power of two and at least two.
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_AW    = $clog2(OUT_DEPTH);

  typedef enum logic {
    OP_HEADER  = 1'b0,
    OP_PAYLOAD = 1'b1
  } opcode_e;

  typedef enum logic [3:0] {
    KIND_TYPE       = 4'd0,
    KIND_GROUP_LEN  = 4'd1,
    KIND_GROUP_BYTE = 4'd2,
    KIND_ID         = 4'd3,
    KIND_TIMESTAMP  = 4'd4,
    KIND_KEY_LEN    = 4'd5,
    KIND_KEY_BYTE   = 4'd6,
    KIND_VALUE_LEN  = 4'd7,
    KIND_VALUE_BYTE = 4'd8,
    KIND_FINAL      = 4'd9
  } field_kind_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_HEADER = 2'd1,
    ST_BROKEN     = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_TYPE   = 4'd1,
    PH_GLEN   = 4'd2,
    PH_GROUP  = 4'd3,
    PH_ID     = 4'd4,
    PH_TS     = 4'd5,
    PH_KLEN   = 4'd6,
    PH_KEY    = 4'd7,
    PH_VLEN   = 4'd8,
    PH_VALUE  = 4'd9,
    PH_BROKEN = 4'd10
  } phase_e;

  typedef struct packed {
    field_kind_e kind;
    logic [63:0] value;
    logic [15:0] index;
    status_e     status;
    logic [15:0] done;
    logic        last;
  } srsp_result_t;

endpackage

>>> rtl/srsp_parser.sv
// Parser state and per-item decode: updates the record state for each accepted item.
module srsp_parser import srsp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         accept_i,
  input  opcode_e      opcode_i,
  input  logic [31:0]  object_count_i,
  input  logic [31:0]  payload_size_i,
  input  logic [7:0]   data_byte_i,
  output logic         push_a_o,
  output srsp_result_t res_a_o,
  output logic         push_b_o,
  output srsp_result_t res_b_o
);

  phase_e      phase_q, phase_d;
  logic [2:0]  fbc_q, fbc_d;
  logic [63:0] acc_q, acc_d;
  logic [31:0] span_q, span_d;
  logic [31:0] rem_q, rem_d;
  logic [15:0] expected_q, expected_d;
  logic [15:0] done_q, done_d;
  logic        stopped_q, stopped_d;

  logic [63:0] acc_ins;
  logic [3:0]  fbc_inc;
  logic [3:0]  field_size;
  logic        full;
  logic        bad;
  logic [15:0] done_inc;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      acc_ins[8*i +: 8] = (fbc_q == 3'(i)) ? data_byte_i : acc_q[8*i +: 8];
    end
    fbc_inc = {1'b0, fbc_q} + 4'd1;
    case (phase_q)
      PH_TYPE:          field_size = 4'd4;
      PH_GLEN, PH_KLEN: field_size = 4'd2;
      default:          field_size = 4'd8;
    endcase
    full     = (fbc_inc >= field_size);
    done_inc = done_q + 16'd1;
  end

  always_comb begin
    phase_d    = phase_q;
    fbc_d      = fbc_q;
    acc_d      = acc_q;
    span_d     = span_q;
    rem_d      = rem_q;
    expected_d = expected_q;
    done_d     = done_q;
    stopped_d  = stopped_q;
    bad        = 1'b0;

    push_a_o       = 1'b0;
    res_a_o        = '0;
    res_a_o.kind   = KIND_TYPE;
    res_a_o.status = ST_OK;
    res_a_o.index  = done_q;
    push_b_o       = 1'b0;
    res_b_o        = '0;
    res_b_o.kind   = KIND_FINAL;
    res_b_o.status = ST_OK;
    res_b_o.last   = 1'b1;

    if (accept_i && opcode_i == OP_HEADER) begin
      phase_d    = PH_IDLE;
      fbc_d      = '0;
      acc_d      = '0;
      span_d     = '0;
      rem_d      = '0;
      expected_d = '0;
      done_d     = '0;
      stopped_d  = 1'b0;
      if (payload_size_i < 32'(MIN_PACKET_BYTES) || object_count_i == 32'd0 ||
          object_count_i > 32'(MAX_RECORDS)) begin
        push_b_o       = 1'b1;
        res_b_o.status = ST_BAD_HEADER;
      end else begin
        expected_d = object_count_i[15:0];
        rem_d      = payload_size_i;
        if (payload_size_i == 32'd0) begin
          push_b_o = 1'b1;
        end else begin
          phase_d = PH_TYPE;
        end
      end
    end else if (accept_i && phase_q != PH_IDLE && rem_q != 32'd0) begin
      rem_d = rem_q - 32'd1;
      if (stopped_q) begin
        phase_d = PH_BROKEN;
      end else begin
        case (phase_q)
          PH_TYPE, PH_GLEN, PH_KLEN, PH_ID, PH_TS, PH_VLEN: begin
            if (!full) begin
              fbc_d = fbc_inc[2:0];
              acc_d = acc_ins;
            end else begin
              fbc_d    = '0;
              acc_d    = '0;
              push_a_o = 1'b1;
              case (phase_q)
                PH_TYPE: begin
                  res_a_o.kind  = KIND_TYPE;
                  res_a_o.value = acc_ins;
                  phase_d       = PH_GLEN;
                end
                PH_GLEN, PH_KLEN: begin
                  res_a_o.kind  = (phase_q == PH_GLEN) ? KIND_GROUP_LEN : KIND_KEY_LEN;
                  res_a_o.value = {48'd0, acc_ins[15:0]};
                  if (acc_ins[15:0] == 16'd0 || {16'd0, acc_ins[15:0]} > rem_d) begin
                    stopped_d = 1'b1;
                  end else begin
                    span_d  = {16'd0, acc_ins[15:0]};
                    phase_d = (phase_q == PH_GLEN) ? PH_GROUP : PH_KEY;
                  end
                end
                PH_ID, PH_TS: begin
                  res_a_o.kind  = (phase_q == PH_ID) ? KIND_ID : KIND_TIMESTAMP;
                  res_a_o.value = acc_ins;
                  phase_d       = (phase_q == PH_ID) ? PH_TS : PH_KLEN;
                end
                default: begin
                  res_a_o.kind  = KIND_VALUE_LEN;
                  res_a_o.value = acc_ins;
                  if (acc_ins == 64'd0) begin
                    done_d = done_inc;
                    if (done_inc >= expected_q) stopped_d = 1'b1;
                    else                        phase_d   = PH_TYPE;
                  end else if (acc_ins > {32'd0, rem_d}) begin
                    stopped_d = 1'b1;
                  end else begin
                    span_d  = acc_ins[31:0];
                    phase_d = PH_VALUE;
                  end
                end
              endcase
            end
          end
          PH_GROUP, PH_KEY: begin
            push_a_o      = 1'b1;
            res_a_o.kind  = (phase_q == PH_GROUP) ? KIND_GROUP_BYTE : KIND_KEY_BYTE;
            res_a_o.value = {56'd0, data_byte_i};
            span_d        = span_q - 32'd1;
            if (span_q == 32'd1) phase_d = (phase_q == PH_GROUP) ? PH_ID : PH_VLEN;
          end
          PH_VALUE: begin
            push_a_o      = 1'b1;
            res_a_o.kind  = KIND_VALUE_BYTE;
            res_a_o.value = {56'd0, data_byte_i};
            span_d        = span_q - 32'd1;
            if (span_q == 32'd1) begin
              done_d = done_inc;
              if (done_inc >= expected_q) stopped_d = 1'b1;
              else                        phase_d   = PH_TYPE;
            end
          end
          default: ;
        endcase
      end

      // The last payload byte closes the packet with a verdict.
      if (rem_d == 32'd0) begin
        bad            = (phase_d == PH_BROKEN) || (!stopped_d && fbc_d != 3'd0);
        push_b_o       = 1'b1;
        res_b_o.status = bad ? ST_BROKEN : ST_OK;
        res_b_o.done   = bad ? 16'd0 : done_d;
        phase_d        = PH_IDLE;
        stopped_d      = 1'b0;
        fbc_d          = '0;
        acc_d          = '0;
        span_d         = '0;
      end
    end

    res_a_o.last = !push_b_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      fbc_q      <= '0;
      acc_q      <= '0;
      span_q     <= '0;
      rem_q      <= '0;
      expected_q <= '0;
      done_q     <= '0;
      stopped_q  <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      fbc_q      <= fbc_d;
      acc_q      <= acc_d;
      span_q     <= span_d;
      rem_q      <= rem_d;
      expected_q <= expected_d;
      done_q     <= done_d;
      stopped_q  <= stopped_d;
    end
  end

endmodule

>>> rtl/srsp_out_fifo.sv
// Result queue that takes up to two results per cycle and hands out one.
module srsp_out_fifo import srsp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_a_i,
  input  srsp_result_t data_a_i,
  input  logic         push_b_i,
  input  srsp_result_t data_b_i,
  output logic         room_o,
  output logic         valid_o,
  input  logic         pop_i,
  output srsp_result_t data_o
);

  srsp_result_t      mem_q [OUT_DEPTH];
  logic [OUT_AW-1:0] wp_q, wp_d;
  logic [OUT_AW-1:0] rp_q, rp_d;
  logic [OUT_AW:0]   cnt_q, cnt_d;
  logic [OUT_AW-1:0] wp_b;
  logic              pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = pop_i && valid_o;
  assign room_o  = (cnt_q <= (OUT_AW+1)'(OUT_DEPTH - 2));
  assign data_o  = mem_q[rp_q];
  assign wp_b    = wp_q + OUT_AW'(push_a_i);

  always_comb begin
    wp_d  = wp_q + OUT_AW'(push_a_i) + OUT_AW'(push_b_i);
    rp_d  = rp_q + OUT_AW'(pop);
    cnt_d = cnt_q + (OUT_AW+1)'(push_a_i) + (OUT_AW+1)'(push_b_i) - (OUT_AW+1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_a_i) mem_q[wp_q] <= data_a_i;
    if (push_b_i) mem_q[wp_b] <= data_b_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> rtl/store_record_stream_parser_unit.sv
// Top level of the store record stream parser: stream ports, parser and result queue.
//
// The block parses a packet of packed key-value records fed one payload byte per item,
// after a header item that gives the record count and payload size. Each record is a
// 32-bit type, a 16-bit group length and group bytes, a 64-bit id, a 64-bit timestamp,
// a 16-bit key length and key bytes, and a 64-bit value length and value bytes, all
// little-endian. Every finished fixed field and every string or value byte leaves as
// one result item; the item carrying the last payload byte also yields a final status
// item with the verdict and the count of complete records, zero for a broken packet. A
// bad header yields only a final status item. The block accepts one item per clock
// cycle while input ready is high: each item is decoded combinationally by the parser,
// and its results enter a four-entry result queue. Input ready is high while the queue
// has room for two results, so with the output side always ready the sustained rate is
// one item per cycle; an item that produces two results takes two output transfers,
// and a slow output side throttles the input through the queue fill level.
module store_record_stream_parser_unit import srsp_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [71:0]   s_axis_tdata,   // object_count[31:0], payload_size[63:32],
                                        // data_byte[71:64]
  input  logic          s_axis_tuser,   // opcode
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [103:0]  m_axis_tdata,   // field_value[63:0], record_index[79:64],
                                        // status[81:80], records_done[97:82], zero pad
  output logic [3:0]    m_axis_tuser,   // field_kind
  output logic          m_axis_tlast    // last
);

  logic         accept;
  logic         push_a;
  logic         push_b;
  srsp_result_t res_a;
  srsp_result_t res_b;
  srsp_result_t head;

  // An item is taken only when the queue can hold both results it may cause.
  assign accept = s_axis_tvalid && s_axis_tready;

  srsp_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .opcode_i       (opcode_e'(s_axis_tuser)),
    .object_count_i (s_axis_tdata[31:0]),
    .payload_size_i (s_axis_tdata[63:32]),
    .data_byte_i    (s_axis_tdata[71:64]),
    .push_a_o       (push_a),
    .res_a_o        (res_a),
    .push_b_o       (push_b),
    .res_b_o        (res_b)
  );

  srsp_out_fifo u_out_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_a_i (push_a),
    .data_a_i (res_a),
    .push_b_i (push_b),
    .data_b_i (res_b),
    .room_o   (s_axis_tready),
    .valid_o  (m_axis_tvalid),
    .pop_i    (m_axis_tready),
    .data_o   (head)
  );

  // Pack the queue head onto the output stream.
  assign m_axis_tdata = {6'd0, head.done, head.status, head.index, head.value};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule
